// ===== rtl/core/record_table_query_engine_defines.svh =====
// Assertion helpers for the record table query engine.
`ifndef RECORD_TABLE_QUERY_ENGINE_DEFINES_SVH
`define RECORD_TABLE_QUERY_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset
`define RTQE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rtqe: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define RTQE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rtqe: next-cycle check failed");

`else

`define RTQE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RTQE_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/core/rtqe_pkg.sv =====
package rtqe_pkg;

    // Field widths
    localparam int OP_W     = 3;
    localparam int KEY_W    = 32;
    localparam int YEAR_W   = 12;
    localparam int PRICE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int CMP_W    = 32;

    // Stream packing
    localparam int IN_TDATA_W  = 80;
    localparam int IN_TUSER_W  = OP_W;
    localparam int OUT_TDATA_W = 80;
    localparam int OUT_TUSER_W = STATUS_W + 1;

    // Default table size
    localparam int DEPTH_DEF = 16;

    // Start value of the oldest-year search
    localparam logic [YEAR_W-1:0] OLDEST_START = 12'd3000;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND    = 3'd0,
        OP_FIND_YEAR = 3'd1,
        OP_REMOVE    = 3'd2,
        OP_OLDEST    = 3'd3,
        OP_PRICIEST  = 3'd4,
        OP_LIST      = 3'd5
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_READ,
        ST_EVAL,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_STATUS
    } t_state;

    typedef enum logic [1:0] {
        CMP_KEY,
        CMP_YEAR,
        CMP_PRICE,
        CMP_ALL
    } t_cmp_mode;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [YEAR_W-1:0]  year;
        logic [PRICE_W-1:0] price;
    } t_entry;

    typedef struct packed {
        logic             eq;
        logic             lt;
        logic             gt;
        logic [CMP_W-1:0] field;
    } t_cmp_res;

    typedef struct packed {
        t_status            status;
        logic [KEY_W-1:0]   key;
        logic [YEAR_W-1:0]  year;
        logic [PRICE_W-1:0] price;
        logic               has_record;
        logic               last;
    } t_result;

endpackage

// ===== rtl/core/rtqe_cmp.sv =====
// Shared compare unit: picks one field of an entry and compares it
// against the reference value of the running operation.
module rtqe_cmp (
    input  rtqe_pkg::t_cmp_mode               i_mode,
    input  rtqe_pkg::t_entry                  i_entry,
    input  logic [rtqe_pkg::CMP_W-1:0]        i_ref,
    output rtqe_pkg::t_cmp_res                o_res
);

    logic [rtqe_pkg::CMP_W-1:0] field;

    // Field select, zero extended to compare width
    always_comb begin
        unique case (i_mode)
            rtqe_pkg::CMP_KEY:   field = rtqe_pkg::CMP_W'(i_entry.key);
            rtqe_pkg::CMP_YEAR:  field = rtqe_pkg::CMP_W'(i_entry.year);
            rtqe_pkg::CMP_PRICE: field = rtqe_pkg::CMP_W'(i_entry.price);
            default:             field = '0;
        endcase
    end

    // One magnitude compare; "list all" matches everything
    always_comb begin
        o_res.field = field;
        o_res.eq    = (i_mode == rtqe_pkg::CMP_ALL) || (field == i_ref);
        o_res.lt    = field < i_ref;
        o_res.gt    = field > i_ref;
    end

endmodule

// ===== rtl/core/rtqe_ctrl.sv =====
`include "record_table_query_engine_defines.svh"

// Sequencer with the record memory. Every scan walks the table one entry
// at a time (read, then evaluate) through the shared compare unit.
module rtqe_ctrl #(
    parameter int DEPTH = rtqe_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [rtqe_pkg::OP_W-1:0]   i_in_op,
    input  rtqe_pkg::t_entry            i_in_entry,
    input  logic                        i_out_free,
    output logic                        o_emit,
    output rtqe_pkg::t_result           o_result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    rtqe_pkg::t_state r_state, n_state;

    logic [rtqe_pkg::OP_W-1:0]  r_op, n_op;
    rtqe_pkg::t_entry           r_arg, n_arg;
    logic [AW-1:0]              r_idx, n_idx;
    logic [AW-1:0]              r_last_idx, n_last_idx;
    logic [CW-1:0]              r_count, n_count;
    logic                       r_pass, n_pass;
    logic                       r_found, n_found;
    logic [rtqe_pkg::CMP_W-1:0] r_ext, n_ext;
    rtqe_pkg::t_status          r_stat, n_stat;

    // Record memory
    rtqe_pkg::t_entry r_mem [DEPTH];
    rtqe_pkg::t_entry r_rdata;
    logic             mem_we;
    logic             mem_re;
    logic [AW-1:0]    mem_waddr;
    logic [AW-1:0]    mem_raddr;
    rtqe_pkg::t_entry mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // Compare unit hookup
    rtqe_pkg::t_cmp_mode        cmp_mode;
    logic [rtqe_pkg::CMP_W-1:0] cmp_ref;
    rtqe_pkg::t_cmp_res         cmp_res;

    always_comb begin
        unique case (r_op)
            rtqe_pkg::OP_REMOVE: begin
                cmp_mode = rtqe_pkg::CMP_KEY;
                cmp_ref  = rtqe_pkg::CMP_W'(r_arg.key);
            end
            rtqe_pkg::OP_FIND_YEAR: begin
                cmp_mode = rtqe_pkg::CMP_YEAR;
                cmp_ref  = rtqe_pkg::CMP_W'(r_arg.year);
            end
            rtqe_pkg::OP_OLDEST: begin
                cmp_mode = rtqe_pkg::CMP_YEAR;
                cmp_ref  = r_ext;
            end
            rtqe_pkg::OP_PRICIEST: begin
                cmp_mode = rtqe_pkg::CMP_PRICE;
                cmp_ref  = r_ext;
            end
            default: begin
                cmp_mode = rtqe_pkg::CMP_ALL;
                cmp_ref  = '0;
            end
        endcase
    end

    rtqe_cmp u_cmp (
        .i_mode  (cmp_mode),
        .i_entry (r_rdata),
        .i_ref   (cmp_ref),
        .o_res   (cmp_res)
    );

    // Scan conditions
    logic is_valid_op;
    logic is_full;
    logic is_last;
    logic more1;
    logic more2;
    logic better;
    logic hit0;
    logic last_match;
    logic idle_wait;
    logic append_go;

    always_comb begin
        is_valid_op = (r_op <= rtqe_pkg::OP_LIST);
        is_full     = (r_count == CW'(DEPTH));
        is_last     = (CW'(r_idx) == (r_count - CW'(1)));
        more1       = ((CW'(r_idx) + CW'(1)) < r_count);
        more2       = ((CW'(r_idx) + CW'(2)) < r_count);
        better      = ((r_op == rtqe_pkg::OP_OLDEST) && cmp_res.lt) ||
                      ((r_op == rtqe_pkg::OP_PRICIEST) && cmp_res.gt);
        hit0        = cmp_res.eq || better;
        last_match  = (r_idx == r_last_idx);
        idle_wait   = (r_state == rtqe_pkg::ST_IDLE) && !i_in_valid;
        append_go   = (r_state == rtqe_pkg::ST_START) &&
                      (r_op == rtqe_pkg::OP_APPEND) && !is_full;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rtqe_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = rtqe_pkg::ST_START;
            end
            rtqe_pkg::ST_START: begin
                if (!is_valid_op) begin
                    n_state = rtqe_pkg::ST_IDLE;
                end else if (r_op == rtqe_pkg::OP_APPEND || r_count == '0) begin
                    n_state = rtqe_pkg::ST_STATUS;
                end else begin
                    n_state = rtqe_pkg::ST_READ;
                end
            end
            rtqe_pkg::ST_READ: begin
                n_state = rtqe_pkg::ST_EVAL;
            end
            rtqe_pkg::ST_EVAL: begin
                if (r_op == rtqe_pkg::OP_REMOVE) begin
                    if (cmp_res.eq) begin
                        n_state = more1 ? rtqe_pkg::ST_SHIFT_RD : rtqe_pkg::ST_STATUS;
                    end else begin
                        n_state = is_last ? rtqe_pkg::ST_STATUS : rtqe_pkg::ST_READ;
                    end
                end else if (!r_pass) begin
                    if (is_last && !(r_found || hit0)) begin
                        n_state = rtqe_pkg::ST_STATUS;
                    end else begin
                        n_state = rtqe_pkg::ST_READ;
                    end
                end else if (cmp_res.eq) begin
                    if (i_out_free) begin
                        n_state = last_match ? rtqe_pkg::ST_IDLE : rtqe_pkg::ST_READ;
                    end
                end else begin
                    n_state = rtqe_pkg::ST_READ;
                end
            end
            rtqe_pkg::ST_SHIFT_RD: begin
                n_state = rtqe_pkg::ST_SHIFT_WR;
            end
            rtqe_pkg::ST_SHIFT_WR: begin
                n_state = more2 ? rtqe_pkg::ST_SHIFT_RD : rtqe_pkg::ST_STATUS;
            end
            rtqe_pkg::ST_STATUS: begin
                if (i_out_free) n_state = rtqe_pkg::ST_IDLE;
            end
            default: n_state = rtqe_pkg::ST_IDLE;
        endcase
    end

    // Outputs and datapath updates
    always_comb begin
        n_op       = r_op;
        n_arg      = r_arg;
        n_idx      = r_idx;
        n_last_idx = r_last_idx;
        n_count    = r_count;
        n_pass     = r_pass;
        n_found    = r_found;
        n_ext      = r_ext;
        n_stat     = r_stat;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = r_idx;
        mem_raddr  = r_idx;
        mem_wdata  = r_rdata;
        o_emit     = 1'b0;
        o_result   = '0;
        o_in_ready = 1'b0;

        unique case (r_state)
            rtqe_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_op  = i_in_op;
                    n_arg = i_in_entry;
                end
            end
            rtqe_pkg::ST_START: begin
                n_idx   = '0;
                n_pass  = 1'b0;
                n_found = 1'b0;
                n_ext   = (r_op == rtqe_pkg::OP_OLDEST) ?
                          rtqe_pkg::CMP_W'(rtqe_pkg::OLDEST_START) : '0;
                if (r_op == rtqe_pkg::OP_APPEND) begin
                    if (is_full) begin
                        n_stat = rtqe_pkg::STAT_FULL;
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = r_count[AW-1:0];
                        mem_wdata = r_arg;
                        n_count   = r_count + CW'(1);
                        n_stat    = rtqe_pkg::STAT_OK;
                    end
                end else begin
                    n_stat = rtqe_pkg::STAT_EMPTY;
                end
            end
            rtqe_pkg::ST_READ: begin
                mem_re = 1'b1;
            end
            rtqe_pkg::ST_EVAL: begin
                if (r_op == rtqe_pkg::OP_REMOVE) begin
                    if (cmp_res.eq) begin
                        if (!more1) begin
                            n_count = r_count - CW'(1);
                            n_stat  = rtqe_pkg::STAT_OK;
                        end
                    end else if (is_last) begin
                        n_stat = rtqe_pkg::STAT_NOT_FOUND;
                    end else begin
                        n_idx = r_idx + AW'(1);
                    end
                end else if (!r_pass) begin
                    // first pass: extreme value and position of the final match
                    if (hit0) begin
                        n_found    = 1'b1;
                        n_last_idx = r_idx;
                    end
                    if (better) n_ext = cmp_res.field;
                    if (is_last) begin
                        n_idx  = '0;
                        n_pass = 1'b1;
                        n_stat = rtqe_pkg::STAT_NOT_FOUND;
                    end else begin
                        n_idx = r_idx + AW'(1);
                    end
                end else if (cmp_res.eq) begin
                    // second pass: emit each match, wait while output is busy
                    if (i_out_free) begin
                        o_emit              = 1'b1;
                        o_result.status     = rtqe_pkg::STAT_OK;
                        o_result.key        = r_rdata.key;
                        o_result.year       = r_rdata.year;
                        o_result.price      = r_rdata.price;
                        o_result.has_record = 1'b1;
                        o_result.last       = last_match;
                        n_idx               = r_idx + AW'(1);
                    end
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            rtqe_pkg::ST_SHIFT_RD: begin
                mem_re    = 1'b1;
                mem_raddr = r_idx + AW'(1);
            end
            rtqe_pkg::ST_SHIFT_WR: begin
                mem_we = 1'b1;
                n_idx  = r_idx + AW'(1);
                if (!more2) begin
                    n_count = r_count - CW'(1);
                    n_stat  = rtqe_pkg::STAT_OK;
                end
            end
            rtqe_pkg::ST_STATUS: begin
                if (i_out_free) begin
                    o_emit          = 1'b1;
                    o_result.status = r_stat;
                    o_result.last   = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rtqe_pkg::ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_arg      <= n_arg;
        r_idx      <= n_idx;
        r_last_idx <= n_last_idx;
        r_pass     <= n_pass;
        r_found    <= n_found;
        r_ext      <= n_ext;
        r_stat     <= n_stat;
    end

    `RTQE_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH))
    `RTQE_ASSERT_IMP(a_emit_free, i_clk, i_rst_n, o_emit, i_out_free)
    `RTQE_ASSERT_IMP(a_status_last, i_clk, i_rst_n, o_emit && !o_result.has_record, o_result.last)
    `RTQE_ASSERT_NXT(a_idle_hold, i_clk, i_rst_n, idle_wait, r_state == rtqe_pkg::ST_IDLE)
    `RTQE_ASSERT_NXT(a_append_grow, i_clk, i_rst_n, append_go, r_count == $past(r_count) + CW'(1))

endmodule

// ===== rtl/core/record_table_query_engine.sv =====
// Channel  | Dir | tdata (low bit up)                     | tuser / tlast
// ---------+-----+----------------------------------------+---------------------------------
// s (cmd)  | in  | record_key, record_year, record_price  | tuser: operation
// m (rslt) | out | out_key, out_year, out_price           | tuser: status, has_record;
//          |     |                                        | tlast: last_result
//
// One command at a time. A query walks the table twice over the single memory
// read port: a first pass finds the extreme value and the final match, and a
// second pass emits each match; with no match the query ends after the first.
// Remove scans to the key, then moves each later record up with a read and a write step.
// Reset clears the state and the record count; no clearing pass runs over the table.
// A stalled result beat holds the sequencer at its emit step.
module record_table_query_engine #(
    parameter int TABLE_DEPTH = rtqe_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // key [31:0], year [43:32], price [75:44], zero pad [79:76]
    input  logic [rtqe_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // operation [2:0]
    input  logic [rtqe_pkg::IN_TUSER_W-1:0]     i_s_tuser,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // key [31:0], year [43:32], price [75:44], zero pad [79:76]
    output logic [rtqe_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    // status [1:0], has_record [2]
    output logic [rtqe_pkg::OUT_TUSER_W-1:0]    o_m_tuser,
    output logic                                o_m_tlast,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready
);

    rtqe_pkg::t_entry  in_entry;
    logic              emit;
    logic              out_free;
    rtqe_pkg::t_result result;
    rtqe_pkg::t_result r_out;
    logic              r_out_valid;

    // Unpack command beat
    always_comb begin
        in_entry.key   = i_s_tdata[31:0];
        in_entry.year  = i_s_tdata[43:32];
        in_entry.price = i_s_tdata[75:44];
    end

    rtqe_ctrl #(
        .DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_in_op    (i_s_tuser),
        .i_in_entry (in_entry),
        .i_out_free (out_free),
        .o_emit     (emit),
        .o_result   (result)
    );

    // Output register: takes a new beat when empty or draining
    assign out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) r_out <= result;
    end

    // Pack result beat
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0, r_out.price, r_out.year, r_out.key};
    assign o_m_tuser  = {r_out.has_record, r_out.status};
    assign o_m_tlast  = r_out.last;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int DEPTH       = rtqe_pkg::DEPTH_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_WAIT  = 100;

    // Reserved opcodes: the engine drops these without a result
    localparam logic [rtqe_pkg::OP_W-1:0] OP_RSVD_A = 3'd6;
    localparam logic [rtqe_pkg::OP_W-1:0] OP_RSVD_B = 3'd7;

    // Table mirror and queue of pending result beats
    class rec_table_scoreboard;
        rtqe_pkg::t_result            pending_q[$];
        logic [rtqe_pkg::KEY_W-1:0]   keys   [DEPTH];
        logic [rtqe_pkg::YEAR_W-1:0]  years  [DEPTH];
        logic [rtqe_pkg::PRICE_W-1:0] prices [DEPTH];
        int                           n_rec;
        int                           n_fail;

        function void push_status(rtqe_pkg::t_status st);
            rtqe_pkg::t_result r;
            r        = '0;
            r.status = st;
            r.last   = 1'b1;
            pending_q.push_back(r);
        endfunction

        // One record beat per selected entry in table order, else not-found
        function void push_hits(logic [DEPTH-1:0] hit);
            rtqe_pkg::t_result r;
            int                total;
            int                n;
            total = 0;
            n     = 0;
            for (int i = 0; i < n_rec; i++)
                if (hit[i])
                    total++;
            if (total == 0) begin
                push_status(rtqe_pkg::STAT_NOT_FOUND);
                return;
            end
            for (int i = 0; i < n_rec; i++) begin
                if (hit[i]) begin
                    n            = n + 1;
                    r            = '0;
                    r.status     = rtqe_pkg::STAT_OK;
                    r.key        = keys[i];
                    r.year       = years[i];
                    r.price      = prices[i];
                    r.has_record = 1'b1;
                    r.last       = (n == total);
                    pending_q.push_back(r);
                end
            end
        endfunction

        // Apply one accepted command beat to the mirror
        function void note_command(logic [rtqe_pkg::OP_W-1:0] op,
                                   logic [rtqe_pkg::KEY_W-1:0] key,
                                   logic [rtqe_pkg::YEAR_W-1:0] year,
                                   logic [rtqe_pkg::PRICE_W-1:0] price);
            logic [DEPTH-1:0]             hit;
            logic [rtqe_pkg::YEAR_W-1:0]  lo_year;
            logic [rtqe_pkg::PRICE_W-1:0] hi_price;
            int                           found;
            hit      = '0;
            lo_year  = rtqe_pkg::OLDEST_START;
            hi_price = '0;
            found    = -1;
            if (op > rtqe_pkg::OP_LIST)
                return;
            if (op == rtqe_pkg::OP_APPEND) begin
                if (n_rec >= DEPTH) begin
                    push_status(rtqe_pkg::STAT_FULL);
                end else begin
                    keys[n_rec]   = key;
                    years[n_rec]  = year;
                    prices[n_rec] = price;
                    n_rec         = n_rec + 1;
                    push_status(rtqe_pkg::STAT_OK);
                end
                return;
            end
            if (n_rec == 0) begin
                push_status(rtqe_pkg::STAT_EMPTY);
                return;
            end
            unique case (op)
                rtqe_pkg::OP_FIND_YEAR: begin
                    for (int i = 0; i < n_rec; i++)
                        hit[i] = (years[i] == year);
                end
                rtqe_pkg::OP_REMOVE: begin
                    for (int i = 0; i < n_rec; i++)
                        if (found < 0 && keys[i] == key)
                            found = i;
                    if (found < 0) begin
                        push_status(rtqe_pkg::STAT_NOT_FOUND);
                    end else begin
                        // later entries close up
                        for (int j = found; j + 1 < n_rec; j++) begin
                            keys[j]   = keys[j+1];
                            years[j]  = years[j+1];
                            prices[j] = prices[j+1];
                        end
                        n_rec = n_rec - 1;
                        push_status(rtqe_pkg::STAT_OK);
                    end
                    return;
                end
                rtqe_pkg::OP_OLDEST: begin
                    for (int i = 0; i < n_rec; i++)
                        if (years[i] < lo_year)
                            lo_year = years[i];
                    for (int i = 0; i < n_rec; i++)
                        hit[i] = (years[i] == lo_year);
                end
                rtqe_pkg::OP_PRICIEST: begin
                    for (int i = 0; i < n_rec; i++)
                        if (prices[i] > hi_price)
                            hi_price = prices[i];
                    for (int i = 0; i < n_rec; i++)
                        hit[i] = (prices[i] == hi_price);
                end
                default: begin
                    hit = '1;
                end
            endcase
            push_hits(hit);
        endfunction

        function void flag_field(string name, logic [31:0] want, logic [31:0] got);
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
            n_fail++;
        endfunction

        // Compare one result beat against the oldest pending one
        function void check_beat(rtqe_pkg::t_result got);
            rtqe_pkg::t_result want;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result beat: expected none, actual 0x%0h",
                         $time, got);
                n_fail++;
                return;
            end
            want = pending_q.pop_front();
            if (got.status !== want.status)
                flag_field("status", 32'(want.status), 32'(got.status));
            if (got.key !== want.key)
                flag_field("key", want.key, got.key);
            if (got.year !== want.year)
                flag_field("year", 32'(want.year), 32'(got.year));
            if (got.price !== want.price)
                flag_field("price", want.price, got.price);
            if (got.has_record !== want.has_record)
                flag_field("has_record", 32'(want.has_record), 32'(got.has_record));
            if (got.last !== want.last)
                flag_field("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic                             i_clk      = 1'b0;
    logic                             i_rst_n    = 1'b0;
    logic [rtqe_pkg::IN_TDATA_W-1:0]  i_s_tdata  = '0;
    logic [rtqe_pkg::IN_TUSER_W-1:0]  i_s_tuser  = '0;
    logic                             i_s_tvalid = 1'b0;
    logic                             o_s_tready;
    logic [rtqe_pkg::OUT_TDATA_W-1:0] o_m_tdata;
    logic [rtqe_pkg::OUT_TUSER_W-1:0] o_m_tuser;
    logic                             o_m_tlast;
    logic                             o_m_tvalid;
    logic                             i_m_tready = 1'b0;

    rec_table_scoreboard sb;
    int                  tx_idle  = 20;
    int                  rx_idle  = 70;
    int unsigned         cycle_cnt = 0;

    record_table_query_engine #(
        .TABLE_DEPTH (DEPTH)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready)
    );

    always #2 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result-side backpressure
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= rx_idle);
    end

    // Beat monitor: results first, then the command accepted on this edge
    always @(posedge i_clk) begin : mon
        rtqe_pkg::t_result beat;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                beat            = '0;
                beat.status     = rtqe_pkg::t_status'(o_m_tuser[rtqe_pkg::STATUS_W-1:0]);
                beat.has_record = o_m_tuser[rtqe_pkg::STATUS_W];
                beat.key        = o_m_tdata[31:0];
                beat.year       = o_m_tdata[43:32];
                beat.price      = o_m_tdata[75:44];
                beat.last       = o_m_tlast;
                sb.check_beat(beat);
            end
            if (i_s_tvalid && o_s_tready)
                sb.note_command(i_s_tuser, i_s_tdata[31:0], i_s_tdata[43:32],
                                i_s_tdata[75:44]);
        end
    end

    // Drive one command beat, with a random lead-in gap
    task automatic send_cmd(input logic [rtqe_pkg::OP_W-1:0] op,
                            input logic [rtqe_pkg::KEY_W-1:0] key,
                            input logic [rtqe_pkg::YEAR_W-1:0] year,
                            input logic [rtqe_pkg::PRICE_W-1:0] price);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle && gap < 30)
            gap++;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tuser  <= op;
        i_s_tdata  <= {4'b0, price, year, key};
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    function automatic logic [rtqe_pkg::KEY_W-1:0] pick_key();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return rtqe_pkg::KEY_W'($urandom_range(31));
        if (roll < 85)
            return 32'hFFFF_FFE0 + $urandom_range(31);
        return $urandom;
    endfunction

    function automatic logic [rtqe_pkg::YEAR_W-1:0] pick_year();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return rtqe_pkg::YEAR_W'(1990 + $urandom_range(7));
        if (roll < 70)
            return rtqe_pkg::YEAR_W'(2999 + $urandom_range(2));
        if (roll < 75)
            return $urandom_range(1) ? 12'hFFF : 12'h000;
        return rtqe_pkg::YEAR_W'($urandom_range(4095));
    endfunction

    function automatic logic [rtqe_pkg::PRICE_W-1:0] pick_price();
        int roll;
        roll = $urandom_range(99);
        if (roll < 50)
            return $urandom_range(3) * 1000;
        if (roll < 60)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // Edges of the fields, every opcode, empty and no-match cases
    task automatic run_directed();
        send_cmd(rtqe_pkg::OP_LIST, '0, '0, '0);
        send_cmd(rtqe_pkg::OP_FIND_YEAR, '0, 12'd2000, '0);
        send_cmd(rtqe_pkg::OP_REMOVE, 32'd1, '0, '0);
        send_cmd(rtqe_pkg::OP_OLDEST, '0, '0, '0);
        send_cmd(rtqe_pkg::OP_PRICIEST, '0, '0, '0);
        send_cmd(rtqe_pkg::OP_APPEND, 32'h0, 12'h000, 32'h0);
        send_cmd(rtqe_pkg::OP_APPEND, 32'hFFFF_FFFF, 12'hFFF, 32'hFFFF_FFFF);
        send_cmd(rtqe_pkg::OP_PRICIEST, '0, '0, '0);
        send_cmd(rtqe_pkg::OP_OLDEST, '0, '0, '0);
        send_cmd(rtqe_pkg::OP_FIND_YEAR, '0, 12'hFFF, '0);
        send_cmd(rtqe_pkg::OP_FIND_YEAR, '0, 12'd1234, '0);
        send_cmd(rtqe_pkg::OP_REMOVE, 32'd5, '0, '0);
        send_cmd(OP_RSVD_A, 32'hFFFF_FFFF, 12'hFFF, 32'hFFFF_FFFF);
        send_cmd(OP_RSVD_B, '0, '0, '0);
        send_cmd(rtqe_pkg::OP_LIST, '0, '0, '0);
        send_cmd(rtqe_pkg::OP_REMOVE, 32'h0, '0, '0);
        send_cmd(rtqe_pkg::OP_REMOVE, 32'hFFFF_FFFF, '0, '0);
        // only years at or above the oldest-search start value
        send_cmd(rtqe_pkg::OP_APPEND, 32'd1, 12'd3500, 32'd10);
        send_cmd(rtqe_pkg::OP_OLDEST, '0, '0, '0);
        send_cmd(rtqe_pkg::OP_APPEND, 32'd2, 12'd3000, 32'd10);
        send_cmd(rtqe_pkg::OP_OLDEST, '0, '0, '0);
        send_cmd(rtqe_pkg::OP_PRICIEST, '0, '0, '0);
        send_cmd(rtqe_pkg::OP_LIST, '0, '0, '0);
    endtask

    // Alternate fill and drain stretches so the table hits both full and empty
    task automatic run_random(input int n_items);
        logic [rtqe_pkg::OP_W-1:0]    op;
        logic [rtqe_pkg::KEY_W-1:0]   key;
        logic [rtqe_pkg::YEAR_W-1:0]  year;
        logic [rtqe_pkg::PRICE_W-1:0] price;
        int                           roll;
        int                           n_sent;
        bit                           filling;
        n_sent  = 0;
        filling = 1'b1;
        while (n_sent < n_items) begin
            roll  = $urandom_range(99);
            key   = pick_key();
            year  = pick_year();
            price = pick_price();
            if (filling)
                op = (roll < 50) ? rtqe_pkg::OP_APPEND    :
                     (roll < 60) ? rtqe_pkg::OP_REMOVE    :
                     (roll < 70) ? rtqe_pkg::OP_FIND_YEAR :
                     (roll < 78) ? rtqe_pkg::OP_OLDEST    :
                     (roll < 86) ? rtqe_pkg::OP_PRICIEST  :
                     (roll < 97) ? rtqe_pkg::OP_LIST      : OP_RSVD_A;
            else
                op = (roll < 12) ? rtqe_pkg::OP_APPEND    :
                     (roll < 55) ? rtqe_pkg::OP_REMOVE    :
                     (roll < 65) ? rtqe_pkg::OP_FIND_YEAR :
                     (roll < 75) ? rtqe_pkg::OP_OLDEST    :
                     (roll < 83) ? rtqe_pkg::OP_PRICIEST  :
                     (roll < 97) ? rtqe_pkg::OP_LIST      : OP_RSVD_A;
            if (op == OP_RSVD_A && $urandom_range(1))
                op = OP_RSVD_B;
            // aim removes and finds mostly at stored entries
            if (sb.n_rec > 0 && $urandom_range(99) < 75) begin
                if (op == rtqe_pkg::OP_REMOVE)
                    key = sb.keys[$urandom_range(sb.n_rec - 1)];
                if (op == rtqe_pkg::OP_FIND_YEAR)
                    year = sb.years[$urandom_range(sb.n_rec - 1)];
            end
            send_cmd(op, key, year, price);
            if (op <= rtqe_pkg::OP_LIST) begin
                n_sent++;
                if (n_sent % 40 == 0)
                    filling = ~filling;
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle = 20;
        rx_idle = 70;
        run_directed();
        run_random(150);

        tx_idle = 70;
        rx_idle = 20;
        run_random(145);

        tx_idle = 0;
        rx_idle = 0;
        run_random(145);

        i_s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (sb.n_fail == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
